[rtl/tevq_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tevq_pkg: shared types and constants of the timed event queue
// Slot count, link encoding, request and status codes, controller
// command and status bundles, and the (time, priority) ordering function.
// ---------------------------------------------------------------------------
package tevq_pkg;

   localparam int SLOT_COUNT = 32;
   localparam int IDX_W      = $clog2(SLOT_COUNT);
   localparam int LINK_W     = $clog2(SLOT_COUNT + 1);
   localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(SLOT_COUNT);

   // field widths of the beats
   localparam int SEC_W    = 32;
   localparam int NSEC_W   = 30;
   localparam int PRIO_W   = 8;
   localparam int TAG_W    = 16;
   localparam int HANDLE_W = 5;
   localparam int SLOT_W   = 5;
   localparam int STATUS_W = 3;
   localparam int REQ_W    = 2;

   // slot record held in the event memory: {tag, priority, nsec, sec}
   localparam int REC_W = SEC_W + NSEC_W + PRIO_W + TAG_W;

   localparam logic signed [SEC_W-1:0]  SEC_INF  = -32'sd1;
   localparam logic signed [PRIO_W-1:0] PRIO_MIN = -8'sd100;
   localparam logic signed [PRIO_W-1:0] PRIO_MAX = 8'sd100;

   typedef enum logic [REQ_W-1:0] {
      REQ_SCHED  = 2'd0,
      REQ_CANCEL = 2'd1,
      REQ_POP    = 2'd2
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_POOL_FULL  = 3'd1,
      ST_BAD_PRIO   = 3'd2,
      ST_BAD_HANDLE = 3'd3,
      ST_NOT_DUE    = 3'd4
   } status_code_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_WALK,
      S_LINK,
      S_POP_CHECK,
      S_RESPOND
   } ctl_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic capture;
      logic bad_prio;
      logic pool_full;
      logic alloc;
      logic walk_adv;
      logic link_insert;
      logic cancel_bad;
      logic cancel_exec;
      logic pop_exec;
      logic pop_miss;
      logic nop_res;
      logic load_rsp;
   } ctl_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic [REQ_W-1:0] req_type;
      logic             prio_bad;
      logic             free_empty;
      logic             queue_empty;
      logic             handle_bad;
      logic             walk_stop;
      logic             walk_last;
      logic             due;
      logic             rsp_free;
   } ctl_stat_type;

   // a strictly ahead of b in (time, priority) order; -1 seconds is infinity
   function automatic logic key_before(
      input logic signed [SEC_W-1:0]  a_sec,
      input logic [NSEC_W-1:0]        a_nsec,
      input logic signed [PRIO_W-1:0] a_prio,
      input logic signed [SEC_W-1:0]  b_sec,
      input logic [NSEC_W-1:0]        b_nsec,
      input logic signed [PRIO_W-1:0] b_prio
   );
      logic t_before;
      logic t_equal;
      if (b_sec == SEC_INF) begin
         t_before = (a_sec >= 0);
      end else if (a_sec == SEC_INF) begin
         t_before = 1'b0;
      end else if (a_sec < b_sec) begin
         t_before = 1'b1;
      end else if (a_sec > b_sec) begin
         t_before = 1'b0;
      end else begin
         t_before = (a_nsec < b_nsec);
      end
      t_equal = (a_sec == b_sec) && (a_nsec == b_nsec);
      return t_before || (t_equal && (a_prio < b_prio));
   endfunction

endpackage

[rtl/timed_event_queue.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// timed_event_queue: sorted discrete event queue over a fixed slot pool
// Schedule, cancel and pop of events kept in (time, priority) order.
// ---------------------------------------------------------------------------
//  channel | dir | ports                           | beat content
//  req     | in  | req_tvalid/tready/tuser/tdata   | one request
//  rsp     | out | rsp_tvalid/tready/tuser/tdata   | one result per request
//
//  One request at a time. An accepted schedule compares the new event with
//  the queued events one link per cycle, up to 31 of them, then links it in;
//  a schedule refused for its priority or a full pool, a cancel and an unused
//  request go from decode to the response, a pop on a non-empty queue through a head check.
//  The response register holds a result while the next request is taken;
//  the block only waits when it has a new result and the old one is unread.
//  Synchronous reset empties the queue and rebuilds the free list at once.
// ---------------------------------------------------------------------------
module timed_event_queue
   import tevq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [REQ_W-1:0]    req_tuser,  // req_type
   input  logic [95:0]         req_tdata,  // when_sec, when_nsec, priority_req, tag, handle
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [STATUS_W-1:0] rsp_tuser,  // status
   output logic [95:0]         rsp_tdata   // slot, event_tag, event_priority,
                                           // now_sec_out, now_nsec_out
);

   ctl_cmd_type  cmd;
   ctl_stat_type stat;

   tevq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tevq_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   // one request in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while another is in flight");

   // failed requests carry no event tag or priority
   a_fail_no_event: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != ST_OK) |-> (rsp_tdata[28:5] == '0))
      else $error("failed result carries event data");

   // only defined status codes
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser <= ST_NOT_DUE))
      else $error("undefined status code");

   // a result is never loaded in the cycle a request is taken
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !rsp_tvalid) |=> !rsp_tvalid)
      else $error("result appeared before request was processed");

endmodule

[rtl/tevq_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tevq_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module tevq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/tevq_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tevq_ctrl: request sequencer of the timed event queue
// Decodes a request, steps the sorted-list walk one link per cycle,
// and hands the finished result to the response register.
// ---------------------------------------------------------------------------
module tevq_ctrl
   import tevq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  ctl_stat_type stat,
   output ctl_cmd_type  cmd
);

   ctl_state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            state_in = S_RESPOND;
            case (stat.req_type)
               REQ_SCHED: begin
                  if (!stat.prio_bad && !stat.free_empty) begin
                     state_in = stat.queue_empty ? S_LINK : S_WALK;
                  end
               end
               REQ_POP: begin
                  if (!stat.queue_empty) state_in = S_POP_CHECK;
               end
               default: state_in = S_RESPOND;
            endcase
         end
         S_WALK: begin
            if (stat.walk_stop || stat.walk_last) state_in = S_LINK;
         end
         S_LINK:      state_in = S_RESPOND;
         S_POP_CHECK: state_in = S_RESPOND;
         S_RESPOND: begin
            if (stat.rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd       = '0;
      req_ready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: cmd.capture = req_valid;
         S_DECODE: begin
            unique case (stat.req_type)
               REQ_SCHED: begin
                  if (stat.prio_bad)        cmd.bad_prio  = 1'b1;
                  else if (stat.free_empty) cmd.pool_full = 1'b1;
                  else                      cmd.alloc     = 1'b1;
               end
               REQ_CANCEL: begin
                  if (stat.handle_bad) cmd.cancel_bad  = 1'b1;
                  else                 cmd.cancel_exec = 1'b1;
               end
               REQ_POP: begin
                  if (stat.queue_empty) cmd.pop_miss = 1'b1;
               end
               default: cmd.nop_res = 1'b1;
            endcase
         end
         S_WALK:      cmd.walk_adv = !stat.walk_stop;
         S_LINK:      cmd.link_insert = 1'b1;
         S_POP_CHECK: begin
            cmd.pop_exec = stat.due;
            cmd.pop_miss = !stat.due;
         end
         S_RESPOND:   cmd.load_rsp = stat.rsp_free;
         default:     cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/tevq_dpath.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tevq_dpath: slot pool, links and time keeping of the timed event queue
// Holds the request, the slot record memory, the doubly linked sorted
// queue, the LIFO free list, the current time and the response register.
// ---------------------------------------------------------------------------
module tevq_dpath
   import tevq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  ctl_cmd_type   cmd,
   output ctl_stat_type  stat,
   input  logic [REQ_W-1:0] req_tuser,
   input  logic [95:0]   req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [STATUS_W-1:0] rsp_tuser,
   output logic [95:0]   rsp_tdata
);

   // request
   logic [REQ_W-1:0]         req_type_ff, req_type_in;
   logic signed [SEC_W-1:0]  sec_ff, sec_in;
   logic [NSEC_W-1:0]        nsec_ff, nsec_in;
   logic signed [PRIO_W-1:0] prio_ff, prio_in;
   logic [TAG_W-1:0]         tag_ff, tag_in;
   logic [HANDLE_W-1:0]      handle_ff, handle_in;

   // walk
   logic [IDX_W-1:0]  new_ff, new_in;
   logic [LINK_W-1:0] cur_ff, cur_in;
   logic [LINK_W-1:0] prev_ff, prev_in;

   // links and occupancy
   logic [LINK_W-1:0] next_ff [SLOT_COUNT];
   logic [LINK_W-1:0] next_in [SLOT_COUNT];
   logic [LINK_W-1:0] back_ff [SLOT_COUNT];
   logic [LINK_W-1:0] back_in [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] in_use_ff, in_use_in;
   logic [LINK_W-1:0] qhead_ff, qhead_in;
   logic [LINK_W-1:0] fhead_ff, fhead_in;

   // time and result
   logic signed [SEC_W-1:0]  now_sec_ff, now_sec_in;
   logic [NSEC_W-1:0]        now_nsec_ff, now_nsec_in;
   logic [STATUS_W-1:0]      res_status_ff, res_status_in;
   logic [SLOT_W-1:0]        res_slot_ff, res_slot_in;
   logic [TAG_W-1:0]         res_tag_ff, res_tag_in;
   logic [PRIO_W-1:0]        res_prio_ff, res_prio_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_user_ff, rsp_user_in;
   logic [95:0]         rsp_data_ff, rsp_data_in;

   // record memory
   logic             ram_wr_en;
   logic [REC_W-1:0] ram_wr_data;
   logic [IDX_W-1:0] ram_rd_addr;
   logic [REC_W-1:0] ram_rd_data;
   logic signed [SEC_W-1:0]  rd_sec;
   logic [NSEC_W-1:0]        rd_nsec;
   logic signed [PRIO_W-1:0] rd_prio;
   logic [TAG_W-1:0]         rd_tag;

   // helpers
   logic [LINK_W-1:0] cur_next;
   logic [LINK_W-1:0] unl;
   logic [IDX_W-1:0]  unl_idx;
   logic [LINK_W-1:0] unl_p;
   logic [LINK_W-1:0] unl_n;
   logic              handle_in_range;
   logic [LINK_W-1:0] handle_link;

   assign rd_sec  = ram_rd_data[SEC_W-1:0];
   assign rd_nsec = ram_rd_data[SEC_W +: NSEC_W];
   assign rd_prio = ram_rd_data[SEC_W+NSEC_W +: PRIO_W];
   assign rd_tag  = ram_rd_data[SEC_W+NSEC_W+PRIO_W +: TAG_W];

   assign cur_next        = next_ff[cur_ff[IDX_W-1:0]];
   assign handle_in_range = (32'(handle_ff) < SLOT_COUNT);
   assign handle_link     = LINK_W'(handle_ff);
   assign unl             = cmd.cancel_exec ? handle_link : qhead_ff;
   assign unl_idx         = unl[IDX_W-1:0];
   assign unl_p           = back_ff[unl_idx];
   assign unl_n           = next_ff[unl_idx];

   // memory ports: read ahead at the next link while walking, else the head
   assign ram_wr_en   = cmd.link_insert;
   assign ram_wr_data = {tag_ff, prio_ff, nsec_ff, sec_ff};
   assign ram_rd_addr = cmd.walk_adv ? cur_next[IDX_W-1:0] : qhead_ff[IDX_W-1:0];

   tevq_ram #(
      .WIDTH (REC_W),
      .DEPTH (SLOT_COUNT)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (new_ff),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // status toward the controller
   always_comb begin
      stat.req_type    = req_type_ff;
      stat.prio_bad    = (prio_ff == '0) || (prio_ff <= PRIO_MIN) || (prio_ff >= PRIO_MAX);
      stat.free_empty  = (fhead_ff == LINK_NULL);
      stat.queue_empty = (qhead_ff == LINK_NULL);
      stat.handle_bad  = !handle_in_range || !in_use_ff[handle_link[IDX_W-1:0]];
      stat.walk_stop   = key_before(sec_ff, nsec_ff, prio_ff, rd_sec, rd_nsec, rd_prio);
      stat.walk_last   = (cur_next == LINK_NULL);
      stat.due         = !key_before(sec_ff, nsec_ff, prio_ff, rd_sec, rd_nsec, rd_prio);
      stat.rsp_free    = !rsp_valid_ff || rsp_tready;
   end

   // request capture
   always_comb begin
      req_type_in = req_type_ff;
      sec_in      = sec_ff;
      nsec_in     = nsec_ff;
      prio_in     = prio_ff;
      tag_in      = tag_ff;
      handle_in   = handle_ff;
      if (cmd.capture) begin
         req_type_in = req_tuser;
         sec_in      = req_tdata[31:0];
         nsec_in     = req_tdata[61:32];
         prio_in     = req_tdata[69:62];
         tag_in      = req_tdata[85:70];
         handle_in   = req_tdata[90:86];
      end
   end

   // list, free list and time updates
   always_comb begin
      new_in      = new_ff;
      cur_in      = cur_ff;
      prev_in     = prev_ff;
      next_in     = next_ff;
      back_in     = back_ff;
      in_use_in   = in_use_ff;
      qhead_in    = qhead_ff;
      fhead_in    = fhead_ff;
      now_sec_in  = now_sec_ff;
      now_nsec_in = now_nsec_ff;

      // pop a slot off the free list and start at the queue head
      if (cmd.alloc) begin
         new_in   = fhead_ff[IDX_W-1:0];
         fhead_in = next_ff[fhead_ff[IDX_W-1:0]];
         prev_in  = LINK_NULL;
         cur_in   = qhead_ff;
      end

      // advance one link
      if (cmd.walk_adv) begin
         prev_in = cur_ff;
         cur_in  = cur_next;
      end

      // splice the new slot between prev and cur
      if (cmd.link_insert) begin
         if (prev_ff == LINK_NULL) qhead_in = LINK_W'(new_ff);
         else next_in[prev_ff[IDX_W-1:0]] = LINK_W'(new_ff);
         if (cur_ff != LINK_NULL) back_in[cur_ff[IDX_W-1:0]] = LINK_W'(new_ff);
         back_in[new_ff]   = prev_ff;
         next_in[new_ff]   = cur_ff;
         in_use_in[new_ff] = 1'b1;
      end

      // unlink a slot and push it onto the free list
      if (cmd.cancel_exec || cmd.pop_exec) begin
         if (unl_p == LINK_NULL) qhead_in = unl_n;
         else next_in[unl_p[IDX_W-1:0]] = unl_n;
         if (unl_n != LINK_NULL) back_in[unl_n[IDX_W-1:0]] = unl_p;
         in_use_in[unl_idx] = 1'b0;
         next_in[unl_idx]   = fhead_ff;
         fhead_in           = unl;
      end

      if (cmd.pop_exec) begin
         now_sec_in  = rd_sec;
         now_nsec_in = rd_nsec;
      end
      if (cmd.pop_miss) begin
         now_sec_in  = sec_ff;
         now_nsec_in = nsec_ff;
      end
   end

   // result fields
   always_comb begin
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_tag_in    = res_tag_ff;
      res_prio_in   = res_prio_ff;
      if (cmd.bad_prio || cmd.pool_full || cmd.pop_miss || cmd.nop_res) begin
         res_slot_in = '0;
         res_tag_in  = '0;
         res_prio_in = '0;
         if (cmd.bad_prio)       res_status_in = ST_BAD_PRIO;
         else if (cmd.pool_full) res_status_in = ST_POOL_FULL;
         else if (cmd.pop_miss)  res_status_in = ST_NOT_DUE;
         else                    res_status_in = ST_OK;
      end
      if (cmd.cancel_bad || cmd.cancel_exec) begin
         res_status_in = cmd.cancel_bad ? ST_BAD_HANDLE : ST_OK;
         res_slot_in   = SLOT_W'(handle_ff);
         res_tag_in    = '0;
         res_prio_in   = '0;
      end
      if (cmd.link_insert) begin
         res_status_in = ST_OK;
         res_slot_in   = SLOT_W'(new_ff);
         res_tag_in    = '0;
         res_prio_in   = '0;
      end
      if (cmd.pop_exec) begin
         res_status_in = ST_OK;
         res_slot_in   = SLOT_W'(qhead_ff[IDX_W-1:0]);
         res_tag_in    = rd_tag;
         res_prio_in   = rd_prio;
      end
   end

   // response register: load a finished result, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_user_in  = res_status_ff;
         rsp_data_in  = {5'b0, now_nsec_ff, now_sec_ff, res_prio_ff, res_tag_ff,
                         res_slot_ff};
      end
   end

   always_ff @(posedge clock) begin
      req_type_ff   <= req_type_in;
      sec_ff        <= sec_in;
      nsec_ff       <= nsec_in;
      prio_ff       <= prio_in;
      tag_ff        <= tag_in;
      handle_ff     <= handle_in;
      new_ff        <= new_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      back_ff       <= back_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_tag_ff    <= res_tag_in;
      res_prio_ff   <= res_prio_in;
      rsp_user_ff   <= rsp_user_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            next_ff[i] <= LINK_W'(i + 1);
         end
         in_use_ff    <= '0;
         qhead_ff     <= LINK_NULL;
         fhead_ff     <= '0;
         now_sec_ff   <= '0;
         now_nsec_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         next_ff      <= next_in;
         in_use_ff    <= in_use_in;
         qhead_ff     <= qhead_in;
         fhead_ff     <= fhead_in;
         now_sec_ff   <= now_sec_in;
         now_nsec_ff  <= now_nsec_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[tb/timed_event_queue_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// timed_event_queue_test: self-checking bench for the timed event queue
// Drives schedule, cancel, pop and unused requests with random gaps on both
// streams. A scoreboard keeps its own sorted slot pool, predicts each result
// and compares every result beat field by field, in order.
// ---------------------------------------------------------------------------
module timed_event_queue_test
   import tevq_pkg::*;
();

   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [TAG_W-1:0]    etag;
      logic [PRIO_W-1:0]   eprio;
      logic [SEC_W-1:0]    now_sec;
      logic [NSEC_W-1:0]   now_nsec;
   } result_type;

   // ------------------------------------------------------------------------
   // Scoreboard: event pool predictor and queue of expected results
   // ------------------------------------------------------------------------
   class event_pool_scoreboard;
      logic [SEC_W-1:0]  ev_sec[SLOT_COUNT];
      logic [NSEC_W-1:0] ev_nsec[SLOT_COUNT];
      logic [PRIO_W-1:0] ev_prio[SLOT_COUNT];
      logic [TAG_W-1:0]  ev_tag[SLOT_COUNT];
      bit                busy[SLOT_COUNT];
      int                order[$];   // queued slots, sorted
      int                free_list[$]; // front is the next slot handed out
      logic [SEC_W-1:0]  cur_sec;
      logic [NSEC_W-1:0] cur_nsec;
      result_type        pending[$];
      int                mismatches;

      function new();
         for (int i = 0; i < SLOT_COUNT; i++) begin
            busy[i] = 0;
            free_list.push_back(i);
         end
         cur_sec = '0;
         cur_nsec = '0;
         mismatches = 0;
      endfunction

      function bit time_before(logic signed [SEC_W-1:0] as, logic [NSEC_W-1:0] an,
                               logic signed [SEC_W-1:0] bs, logic [NSEC_W-1:0] bn);
         if (bs == -1) return as >= 0;
         if (as == -1) return 0;
         if (as != bs) return as < bs;
         return an < bn;
      endfunction

      // key (s, n, p) is strictly ahead of the event in slot e
      function bit key_ahead(logic [SEC_W-1:0] s, logic [NSEC_W-1:0] n,
                             logic signed [PRIO_W-1:0] p, int e);
         if (time_before(s, n, ev_sec[e], ev_nsec[e])) return 1;
         return s == ev_sec[e] && n == ev_nsec[e] && p < $signed(ev_prio[e]);
      endfunction

      function void release_slot(int e);
         foreach (order[i]) if (order[i] == e) begin
            order.delete(i);
            break;
         end
         busy[e] = 0;
         free_list.push_front(e);
      endfunction

      function void note_request(logic [REQ_W-1:0] kind, logic [SEC_W-1:0] s,
                                 logic [NSEC_W-1:0] n, logic signed [PRIO_W-1:0] p,
                                 logic [TAG_W-1:0] t, logic [HANDLE_W-1:0] h);
         result_type r;
         int e, pos;
         r = '0;
         case (kind)
            REQ_SCHED: begin
               if (p <= PRIO_MIN || p >= PRIO_MAX || p == 0) begin
                  r.status = ST_BAD_PRIO;
               end else if (free_list.size() == 0) begin
                  r.status = ST_POOL_FULL;
               end else begin
                  e = free_list.pop_front();
                  ev_sec[e] = s; ev_nsec[e] = n; ev_prio[e] = p; ev_tag[e] = t;
                  busy[e] = 1;
                  pos = order.size();
                  foreach (order[i]) if (key_ahead(s, n, p, order[i])) begin
                     pos = i;
                     break;
                  end
                  order.insert(pos, e);
                  r.slot = SLOT_W'(e);
               end
            end
            REQ_CANCEL: begin
               r.slot = h;
               if (!busy[h]) r.status = ST_BAD_HANDLE;
               else release_slot(h);
            end
            REQ_POP: begin
               if (order.size() != 0 && !key_ahead(s, n, p, order[0])) begin
                  e = order[0];
                  cur_sec = ev_sec[e]; cur_nsec = ev_nsec[e];
                  r.slot = SLOT_W'(e); r.etag = ev_tag[e]; r.eprio = ev_prio[e];
                  release_slot(e);
               end else begin
                  cur_sec = s; cur_nsec = n;
                  r.status = ST_NOT_DUE;
               end
            end
            default: ;
         endcase
         r.now_sec = cur_sec;
         r.now_nsec = cur_nsec;
         pending.push_back(r);
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %h", got);
            return;
         end
         want = pending.pop_front();
         if (got.status !== want.status || got.slot !== want.slot ||
             got.etag !== want.etag || got.eprio !== want.eprio ||
             got.now_sec !== want.now_sec || got.now_nsec !== want.now_nsec) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch st/slot/tag/prio/sec/nsec",
                         " exp %0d %0d %h %h %h %h got %0d %0d %h %h %h %h"},
                        want.status, want.slot, want.etag, want.eprio, want.now_sec,
                        want.now_nsec, got.status, got.slot, got.etag, got.eprio,
                        got.now_sec, got.now_nsec);
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_tvalid, req_tready, rsp_tvalid, rsp_tready;
   logic [REQ_W-1:0] req_tuser;
   logic [95:0] req_tdata;
   logic [STATUS_W-1:0] rsp_tuser;
   logic [95:0] rsp_tdata;
   event_pool_scoreboard board;
   int idle_cycles;
   bit stim_done;

   timed_event_queue DUT (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // pick a gap length: mostly none or short, sometimes long
   function int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // send one request beat; hold valid until accepted
   task send_request(logic [REQ_W-1:0] kind, logic [SEC_W-1:0] s, logic [NSEC_W-1:0] n,
                     logic [PRIO_W-1:0] p, logic [TAG_W-1:0] t, logic [HANDLE_W-1:0] h);
      int gap;
      gap = gap_length();
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {35'd0, h, t, p, n, s};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(kind, s, n, p, t, h);
   endtask

   task drop_valid();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task wait_drained();
      drop_valid();
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   // random time close to a small set of values so equal keys happen
   task random_time(output logic [SEC_W-1:0] s, output logic [NSEC_W-1:0] n);
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) s = '1;
      else if (r == 1) s = $urandom();
      else if (r == 2) s = 32'h7fffffff;
      else s = $urandom_range(0, 6);
      r = $urandom_range(0, 9);
      if (r == 0) n = NSEC_W'($urandom());
      else if (r == 1) n = 30'd999999999;
      else n = NSEC_W'($urandom_range(0, 3));
   endtask

   function logic [PRIO_W-1:0] random_prio();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return PRIO_W'($urandom());
      return $urandom_range(0, 1) ? 8'($urandom_range(1, 3)) : -8'($urandom_range(1, 3));
   endfunction

   // result side: random back-pressure, check each accepted beat
   initial begin
      result_type got;
      int stall;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         stall = gap_length();
         repeat (stall) begin
            rsp_tready <= 1'b0;
            @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tuser;
            {got.now_nsec, got.now_sec, got.eprio, got.etag, got.slot} = rsp_tdata[90:0];
            board.check_result(got);
         end
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (reset || stim_done || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timed_event_queue_test: FAIL");
         $finish;
      end
   end

   initial begin
      logic [SEC_W-1:0] s;
      logic [NSEC_W-1:0] n;
      logic [PRIO_W-1:0] p;
      int r;
      board = new();
      stim_done = 0;
      idle_cycles = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = '0;
      req_tdata = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: pop on empty, priority bounds, infinity, unused code, bad handle
      send_request(REQ_POP, 32'd5, 30'd7, 8'sd0, 16'd0, 5'd0);
      send_request(REQ_SCHED, 32'd1, 30'd0, 8'sd0, 16'h1111, 5'd0);
      send_request(REQ_SCHED, 32'd1, 30'd0, -8'sd100, 16'h1111, 5'd0);
      send_request(REQ_SCHED, 32'd1, 30'd0, 8'sd100, 16'h1111, 5'd0);
      send_request(REQ_SCHED, 32'd1, 30'd0, 8'h80, 16'h1111, 5'd0);
      send_request(REQ_SCHED, 32'd1, 30'd0, 8'sd127, 16'h1111, 5'd0);
      send_request(REQ_SCHED, 32'hffffffff, 30'h3fffffff, 8'sd99, 16'hffff, 5'd0);
      send_request(REQ_SCHED, 32'h7fffffff, 30'd999999999, -8'sd99, 16'h0001, 5'd0);
      send_request(REQ_SCHED, 32'd3, 30'd4, 8'sd5, 16'h00a5, 5'd0);
      send_request(REQ_SCHED, 32'd3, 30'd4, 8'sd5, 16'h00a6, 5'd0);
      send_request(REQ_SCHED, 32'd3, 30'd4, -8'sd2, 16'h00a7, 5'd0);
      send_request(REQ_UNUSED, 32'hffffffff, 30'h3fffffff, 8'hff, 16'hffff, 5'd31);
      send_request(REQ_CANCEL, 32'd0, 30'd0, 8'sd0, 16'd0, 5'd31);
      send_request(REQ_CANCEL, 32'd0, 30'd0, 8'sd0, 16'd0, 5'd1);
      send_request(REQ_CANCEL, 32'd0, 30'd0, 8'sd0, 16'd0, 5'd1);
      send_request(REQ_POP, 32'd3, 30'd4, -8'sd3, 16'd0, 5'd0);
      send_request(REQ_POP, 32'd3, 30'd4, 8'sd127, 16'd0, 5'd0);
      send_request(REQ_POP, 32'd3, 30'd4, 8'sd127, 16'd0, 5'd0);
      send_request(REQ_POP, 32'hffffffff, 30'd0, 8'h80, 16'd0, 5'd0);
      send_request(REQ_POP, 32'hffffffff, 30'd0, 8'sd127, 16'd0, 5'd0);
      send_request(REQ_POP, 32'hffffffff, 30'd0, 8'sd127, 16'd0, 5'd0);
      wait_drained();

      // random: phases of filling (to pool full) and draining
      for (int i = 0; i < 1550; i++) begin
         random_time(s, n);
         p = random_prio();
         r = $urandom_range(0, 99);
         if (((i / 200) % 2 == 0 && r < 70) || ((i / 200) % 2 == 1 && r < 25))
            send_request(REQ_SCHED, s, n, p, 16'($urandom()), 5'd0);
         else if (r < 85)
            send_request(REQ_CANCEL, s, n, p, 16'($urandom()), 5'($urandom()));
         else if (r < 98)
            send_request(REQ_POP, s, n, p, 16'($urandom()), 5'($urandom()));
         else
            send_request(REQ_UNUSED, s, n, p, 16'($urandom()), 5'($urandom()));
         if (i == 700) wait_drained();
      end
      drop_valid();
      while (board.pending.size() != 0) @(posedge clock);
      stim_done = 1;
      repeat (50) @(posedge clock);
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("timed_event_queue_test: PASS");
      else
         $display("timed_event_queue_test: FAIL");
      $finish;
   end

endmodule
